/* hw/rtl/lws_pkg.sv */
`timescale 1ns / 1ps
package lws_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int NUM_SLOTS_DEF    = 16;

    localparam logic [2:0] FUNC_RECORD = 3'd0;
    localparam logic [2:0] FUNC_MAX    = 3'd1;
    localparam logic [2:0] FUNC_RECENT = 3'd2;
    localparam logic [2:0] FUNC_LOAD   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic CFG_HOLE_SIZE     = 1'b0;
    localparam logic CFG_MIN_SLOT_LOAD = 1'b1;

    localparam logic [3:0]  HOLE_SIZE_RST     = 4'd2;
    localparam logic [15:0] MIN_SLOT_LOAD_RST = 16'd4;

    typedef struct packed {
        logic [31:0] index;
        logic [31:0] count;
        logic [31:0] tmo;
        logic [63:0] sum;
    } slot_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

/* hw/rtl/lws_window.sv */
`timescale 1ns / 1ps
module lws_window #(
    parameter int WINDOW_DEPTH = lws_pkg::WINDOW_DEPTH_DEF,
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_lat,
    input  logic          wr_tmo,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_lat,
    output logic          rd_tmo
);

    logic [31:0] lat_mem [WINDOW_DEPTH];
    logic        tmo_mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lat_mem[wr_addr] <= wr_lat;
            tmo_mem[wr_addr] <= wr_tmo;
        end
        rd_lat <= lat_mem[rd_addr];
        rd_tmo <= tmo_mem[rd_addr];
    end

endmodule

/* hw/rtl/lws_slots.sv */
`timescale 1ns / 1ps
module lws_slots #(
    parameter int NUM_SLOTS = lws_pkg::NUM_SLOTS_DEF,
    localparam int SW = $clog2(NUM_SLOTS)
)(
    input  logic           clk,
    input  logic           wr_en,
    input  logic [SW-1:0]  wr_addr,
    input  lws_pkg::slot_t wr_data,
    input  logic [SW-1:0]  rd_addr,
    output lws_pkg::slot_t rd_data
);

    lws_pkg::slot_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/latency_window_statistics.sv */
`timescale 1ns / 1ps
// Latency window statistics.
// An item is taken when start is high and busy is low. func selects a record,
// a window maximum query, a recent-slot totals query, a load start query or a
// clear. Every item returns one result, shown for one cycle with done high.
// The receiver cannot hold results off.
// After the edge that takes a record, the window ring and the slot ring are
// read, the registered data is waited for, the totals are updated, and the
// result register is loaded, which shows done.
// A max query walks the window ring through its single read port, one entry a
// cycle, visiting each entry that holds data.
// Recent and load queries walk the slot ring backward from the newest slot,
// one slot a cycle, until the filled slots run out or the walk stops early.
// Clear and unknown codes go straight from the read state to the output state.
// busy stays high until the cycle that shows done, when a new item may start.
// Configuration writes go over cfg_valid / cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and writes are meant for idle periods.
// Reset empties the window, the slot ring and all totals, and loads the
// registers with hole size 2 and least slot load 4. Fill counts mark which
// memory entries hold data, so the memories need no clearing pass.
module latency_window_statistics #(
    parameter int WINDOW_DEPTH = lws_pkg::WINDOW_DEPTH_DEF,
    parameter int NUM_SLOTS    = lws_pkg::NUM_SLOTS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [31:0] time_idx,
    input  logic [31:0] since_idx,
    input  logic [31:0] latency,
    input  logic        timed_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [31:0] total_count,
    output logic [31:0] total_timeouts,
    output logic [63:0] total_time,
    output logic [5:0]  window_count,
    output logic [5:0]  window_timeouts,
    output logic [36:0] window_time,
    output logic [31:0] max_time,
    output logic [31:0] recent_count,
    output logic [31:0] recent_timeouts,
    output logic [63:0] recent_time,
    output logic [31:0] load_start_idx
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [FW-1:0] WIN_FULL  = FW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] SLOT_FULL = CW'(NUM_SLOTS);
    localparam logic [AW-1:0] WIN_LAST  = AW'(WINDOW_DEPTH - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_REC  = 4'd2;
    localparam logic [3:0] ST_MAX  = 4'd3;
    localparam logic [3:0] ST_WALK = 4'd4;
    localparam logic [3:0] ST_OUT  = 4'd5;
    localparam logic [3:0] ST_REC2 = 4'd6;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  hole_reg;
    logic [15:0] minload_reg;
    logic [2:0]  func_reg;
    logic [31:0] tidx_reg, since_reg, lat_reg;
    logic        tmo_reg;

    logic [AW-1:0] sptr_reg;
    logic [FW-1:0] sfill_reg;
    logic [36:0]   wsum_reg;
    logic [5:0]    wtmo_reg;
    logic [31:0]   lcount_reg, ltmo_reg;
    logic [63:0]   lsum_reg;
    logic [SW-1:0] slptr_reg;
    logic [CW-1:0] slfill_reg;

    logic [AW-1:0] wcnt_reg;
    logic [FW-1:0] wleft_reg;
    logic [SW-1:0] widx_reg;
    logic [CW-1:0] nleft_reg;
    logic          rvalid_reg;
    logic          stop_reg;
    logic [31:0]   acc_a_reg, acc_b_reg;
    logic [63:0]   acc_s_reg;

    logic          w_we, s_we;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rlat;
    logic          w_rtmo;
    logic [SW-1:0] s_waddr, s_raddr;
    lws_pkg::slot_t s_wdata, s_rdata;

    lws_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
        .clk(clk), .wr_en(w_we), .wr_addr(sptr_reg), .wr_lat(lat_reg),
        .wr_tmo(tmo_reg), .rd_addr(w_raddr), .rd_lat(w_rlat), .rd_tmo(w_rtmo)
    );

    lws_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
        .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
        .rd_addr(s_raddr), .rd_data(s_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    logic [32:0] reach;
    logic        new_slot;
    logic [31:0] eff_tidx;
    logic [SW-1:0] slptr_inc;

    always_comb
    begin
        reach     = {1'b0, s_rdata.index} + 33'(hole_reg);
        eff_tidx  = (s_rdata.index > tidx_reg) ? s_rdata.index : tidx_reg;
        new_slot  = (slfill_reg == '0) || (s_rdata.index < tidx_reg);
        slptr_inc = (slptr_reg == SW'(NUM_SLOTS - 1)) ? '0 : slptr_reg + 1'b1;
        w_raddr   = (state_reg == ST_MAX) ? wcnt_reg : sptr_reg;
        s_raddr   = (state_reg == ST_WALK) ? widx_reg : slptr_reg;
        if (state_reg == ST_IDLE)
        begin
            w_raddr = sptr_reg;
        end
        w_we      = (state_reg == ST_REC);
        s_we      = (state_reg == ST_REC);
        s_waddr   = ((slfill_reg != '0) && new_slot) ? slptr_inc : slptr_reg;
        if (new_slot)
        begin
            s_wdata.index = (slfill_reg == '0) ? tidx_reg : eff_tidx;
            s_wdata.count = 32'd1;
            s_wdata.tmo   = {31'd0, tmo_reg};
            s_wdata.sum   = {32'd0, lat_reg};
        end
        else
        begin
            s_wdata.index = s_rdata.index;
            s_wdata.count = lws_pkg::sat_add32(s_rdata.count, 32'd1);
            s_wdata.tmo   = lws_pkg::sat_add32(s_rdata.tmo, {31'd0, tmo_reg});
            s_wdata.sum   = lws_pkg::sat_add64(s_rdata.sum, {32'd0, lat_reg});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_RD;
            ST_RD:
            begin
                unique case (func_reg)
                    lws_pkg::FUNC_RECORD: state_next = ST_REC2;
                    lws_pkg::FUNC_MAX:    state_next = ST_MAX;
                    lws_pkg::FUNC_RECENT,
                    lws_pkg::FUNC_LOAD:   state_next = ST_WALK;
                    default:              state_next = ST_OUT;
                endcase
            end
            ST_REC2: state_next = ST_REC;
            ST_REC:  state_next = ST_OUT;
            ST_MAX:  if (wleft_reg == '0 && !rvalid_reg) state_next = ST_OUT;
            ST_WALK: if ((nleft_reg == '0 || stop_reg) && !rvalid_reg) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hole_reg        <= lws_pkg::HOLE_SIZE_RST;
            minload_reg     <= lws_pkg::MIN_SLOT_LOAD_RST;
            sptr_reg        <= '0;
            sfill_reg       <= '0;
            wsum_reg        <= '0;
            wtmo_reg        <= '0;
            lcount_reg      <= '0;
            ltmo_reg        <= '0;
            lsum_reg        <= '0;
            slptr_reg       <= '0;
            slfill_reg      <= '0;
            done            <= 1'b0;
            rvalid_reg      <= 1'b0;
            stop_reg        <= 1'b0;
            wcnt_reg        <= '0;
            wleft_reg       <= '0;
            widx_reg        <= '0;
            nleft_reg       <= '0;
            acc_a_reg       <= '0;
            acc_b_reg       <= '0;
            acc_s_reg       <= '0;
            total_count     <= '0;
            total_timeouts  <= '0;
            total_time      <= '0;
            window_count    <= '0;
            window_timeouts <= '0;
            window_time     <= '0;
            max_time        <= '0;
            recent_count    <= '0;
            recent_timeouts <= '0;
            recent_time     <= '0;
            load_start_idx  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == lws_pkg::CFG_HOLE_SIZE)
                begin
                    hole_reg <= cfg_data[3:0];
                end
                else
                begin
                    minload_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    rvalid_reg <= 1'b0;
                    stop_reg   <= 1'b0;
                end
                ST_RD:
                begin
                    wcnt_reg   <= '0;
                    wleft_reg  <= sfill_reg;
                    widx_reg   <= slptr_reg;
                    nleft_reg  <= slfill_reg;
                    acc_a_reg  <= (func_reg == lws_pkg::FUNC_LOAD) ? tidx_reg : '0;
                    acc_b_reg  <= '0;
                    acc_s_reg  <= '0;
                    if (func_reg == lws_pkg::FUNC_CLEAR)
                    begin
                        sptr_reg   <= '0;
                        sfill_reg  <= '0;
                        wsum_reg   <= '0;
                        wtmo_reg   <= '0;
                        lcount_reg <= '0;
                        ltmo_reg   <= '0;
                        lsum_reg   <= '0;
                        slptr_reg  <= '0;
                        slfill_reg <= '0;
                    end
                end
                ST_REC2: ;
                ST_REC:
                begin
                    if (new_slot)
                    begin
                        if (slfill_reg == '0)
                        begin
                            slfill_reg <= CW'(1);
                        end
                        else
                        begin
                            slptr_reg <= slptr_inc;
                            if (slfill_reg != SLOT_FULL)
                            begin
                                slfill_reg <= slfill_reg + 1'b1;
                            end
                        end
                    end
                    lcount_reg <= lws_pkg::sat_add32(lcount_reg, 32'd1);
                    ltmo_reg   <= lws_pkg::sat_add32(ltmo_reg, {31'd0, tmo_reg});
                    lsum_reg   <= lws_pkg::sat_add64(lsum_reg, {32'd0, lat_reg});
                    if (sfill_reg == WIN_FULL)
                    begin
                        wsum_reg <= wsum_reg - {5'd0, w_rlat} + {5'd0, lat_reg};
                        wtmo_reg <= wtmo_reg - {5'd0, w_rtmo} + {5'd0, tmo_reg};
                    end
                    else
                    begin
                        wsum_reg  <= wsum_reg + {5'd0, lat_reg};
                        wtmo_reg  <= wtmo_reg + {5'd0, tmo_reg};
                        sfill_reg <= sfill_reg + 1'b1;
                    end
                    sptr_reg <= (sptr_reg == WIN_LAST) ? '0 : sptr_reg + 1'b1;
                end
                ST_MAX:
                begin
                    rvalid_reg <= (wleft_reg != '0);
                    if (wleft_reg != '0)
                    begin
                        wleft_reg <= wleft_reg - 1'b1;
                        wcnt_reg  <= wcnt_reg + 1'b1;
                    end
                    if (rvalid_reg && w_rlat > acc_a_reg)
                    begin
                        acc_a_reg <= w_rlat;
                    end
                end
                ST_WALK:
                begin
                    rvalid_reg <= (nleft_reg != '0) && !stop_reg;
                    if (nleft_reg != '0 && !stop_reg)
                    begin
                        nleft_reg <= nleft_reg - 1'b1;
                        widx_reg  <= (widx_reg == '0) ? SW'(NUM_SLOTS - 1) : widx_reg - 1'b1;
                    end
                    if (rvalid_reg && !stop_reg)
                    begin
                        if (func_reg == lws_pkg::FUNC_RECENT)
                        begin
                            if (s_rdata.index >= since_reg)
                            begin
                                acc_a_reg <= lws_pkg::sat_add32(acc_a_reg, s_rdata.count);
                                acc_b_reg <= lws_pkg::sat_add32(acc_b_reg, s_rdata.tmo);
                                acc_s_reg <= lws_pkg::sat_add64(acc_s_reg, s_rdata.sum);
                            end
                            else
                            begin
                                stop_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            if (reach < {1'b0, acc_a_reg} || reach < {1'b0, since_reg})
                            begin
                                stop_reg <= 1'b1;
                            end
                            else if (s_rdata.count >= {16'd0, minload_reg})
                            begin
                                acc_a_reg <= s_rdata.index;
                            end
                        end
                    end
                end
                ST_OUT:
                begin
                    done            <= 1'b1;
                    total_count     <= lcount_reg;
                    total_timeouts  <= ltmo_reg;
                    total_time      <= lsum_reg;
                    window_count    <= 6'(sfill_reg);
                    window_timeouts <= wtmo_reg;
                    window_time     <= wsum_reg;
                    max_time        <= (func_reg == lws_pkg::FUNC_MAX) ? acc_a_reg : '0;
                    recent_count    <= (func_reg == lws_pkg::FUNC_RECENT) ? acc_a_reg : '0;
                    recent_timeouts <= (func_reg == lws_pkg::FUNC_RECENT) ? acc_b_reg : '0;
                    recent_time     <= (func_reg == lws_pkg::FUNC_RECENT) ? acc_s_reg : '0;
                    load_start_idx  <= (func_reg == lws_pkg::FUNC_LOAD) ? acc_a_reg : '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            func_reg  <= func;
            tidx_reg  <= time_idx;
            since_reg <= since_idx;
            lat_reg   <= latency;
            tmo_reg   <= timed_out;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) sfill_reg <= WIN_FULL)
        else $error("window fill beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) slfill_reg <= SLOT_FULL)
        else $error("slot fill beyond ring size");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

endmodule

/* tb/latency_window_statistics_checker.sv */
`timescale 1ns / 1ps
module latency_window_statistics_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  func,
    input  logic [31:0] time_idx,
    input  logic [31:0] since_idx,
    input  logic [31:0] latency,
    input  logic        timed_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic [31:0] total_count,
    input  logic [31:0] total_timeouts,
    input  logic [63:0] total_time,
    input  logic [5:0]  window_count,
    input  logic [5:0]  window_timeouts,
    input  logic [36:0] window_time,
    input  logic [31:0] max_time,
    input  logic [31:0] recent_count,
    input  logic [31:0] recent_timeouts,
    input  logic [63:0] recent_time,
    input  logic [31:0] load_start_idx,
    output int          mismatches,
    output int          pending
);

    typedef struct {
        logic [31:0] cnt;
        logic [31:0] tmo;
        logic [63:0] tim;
        logic [5:0]  wcnt;
        logic [5:0]  wtmo;
        logic [36:0] wsum;
        logic [31:0] maxv;
        logic [31:0] rcnt;
        logic [31:0] rtmo;
        logic [63:0] rsum;
        logic [31:0] lstart;
    } stats_t;

    stats_t stats_q[$];

    logic [3:0]  hole;
    logic [15:0] min_load;
    logic [31:0] win_lat [lws_pkg::WINDOW_DEPTH_DEF];
    logic        win_to [lws_pkg::WINDOW_DEPTH_DEF];
    int          win_ptr;
    int          win_fill;
    logic [36:0] win_sum;
    logic [5:0]  win_tmo;
    logic [31:0] life_cnt;
    logic [31:0] life_tmo;
    logic [63:0] life_sum;
    logic [31:0] sl_idx [lws_pkg::NUM_SLOTS_DEF];
    logic [31:0] sl_cnt [lws_pkg::NUM_SLOTS_DEF];
    logic [31:0] sl_tmo [lws_pkg::NUM_SLOTS_DEF];
    logic [63:0] sl_sum [lws_pkg::NUM_SLOTS_DEF];
    int          sl_ptr;
    int          sl_fill;

    assign pending = stats_q.size();

    function automatic logic [31:0] add32_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [63:0] add64_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    task automatic empty_all();
        win_ptr = 0;
        win_fill = 0;
        win_sum = '0;
        win_tmo = '0;
        life_cnt = '0;
        life_tmo = '0;
        life_sum = '0;
        sl_ptr = 0;
        sl_fill = 0;
    endtask

    task automatic record_sample(logic [31:0] t, logic [31:0] lat, logic to);
        logic [31:0] tt;
        tt = t;
        if (sl_fill == 0)
        begin
            sl_idx[sl_ptr] = tt;
            sl_cnt[sl_ptr] = '0;
            sl_tmo[sl_ptr] = '0;
            sl_sum[sl_ptr] = '0;
            sl_fill = 1;
        end
        else
        begin
            if (sl_idx[sl_ptr] > tt)
                tt = sl_idx[sl_ptr];
            if (sl_idx[sl_ptr] < tt)
            begin
                if (sl_fill < lws_pkg::NUM_SLOTS_DEF)
                    sl_fill++;
                sl_ptr = (sl_ptr + 1) % lws_pkg::NUM_SLOTS_DEF;
                sl_idx[sl_ptr] = tt;
                sl_cnt[sl_ptr] = '0;
                sl_tmo[sl_ptr] = '0;
                sl_sum[sl_ptr] = '0;
            end
        end
        sl_cnt[sl_ptr] = add32_sat(sl_cnt[sl_ptr], 32'd1);
        sl_tmo[sl_ptr] = add32_sat(sl_tmo[sl_ptr], {31'd0, to});
        sl_sum[sl_ptr] = add64_sat(sl_sum[sl_ptr], {32'd0, lat});
        life_cnt = add32_sat(life_cnt, 32'd1);
        life_tmo = add32_sat(life_tmo, {31'd0, to});
        life_sum = add64_sat(life_sum, {32'd0, lat});
        if (win_fill >= lws_pkg::WINDOW_DEPTH_DEF)
        begin
            win_sum = win_sum - {5'd0, win_lat[win_ptr]};
            win_tmo = win_tmo - {5'd0, win_to[win_ptr]};
            win_fill--;
        end
        win_lat[win_ptr] = lat;
        win_to[win_ptr] = to;
        win_sum = win_sum + {5'd0, lat};
        win_tmo = win_tmo + {5'd0, to};
        win_ptr = (win_ptr + 1) % lws_pkg::WINDOW_DEPTH_DEF;
        win_fill++;
    endtask

    task automatic predict_stats(output stats_t r);
        int k;
        int n;
        logic [32:0] reach;
        r.maxv = '0;
        r.rcnt = '0;
        r.rtmo = '0;
        r.rsum = '0;
        r.lstart = '0;
        case (func)
            lws_pkg::FUNC_RECORD: record_sample(time_idx, latency, timed_out);
            lws_pkg::FUNC_MAX:
                for (k = 0; k < win_fill; k++)
                    if (win_lat[k] > r.maxv)
                        r.maxv = win_lat[k];
            lws_pkg::FUNC_RECENT:
            begin
                k = sl_ptr;
                for (n = sl_fill; n > 0 && sl_idx[k] >= since_idx; n--)
                begin
                    r.rcnt = add32_sat(r.rcnt, sl_cnt[k]);
                    r.rtmo = add32_sat(r.rtmo, sl_tmo[k]);
                    r.rsum = add64_sat(r.rsum, sl_sum[k]);
                    k = (k == 0) ? lws_pkg::NUM_SLOTS_DEF - 1 : k - 1;
                end
            end
            lws_pkg::FUNC_LOAD:
            begin
                r.lstart = time_idx;
                k = sl_ptr;
                for (n = sl_fill; n > 0; n--)
                begin
                    reach = {1'b0, sl_idx[k]} + {29'd0, hole};
                    if (reach < {1'b0, r.lstart} || reach < {1'b0, since_idx})
                        break;
                    if (sl_cnt[k] >= {16'd0, min_load})
                        r.lstart = sl_idx[k];
                    k = (k == 0) ? lws_pkg::NUM_SLOTS_DEF - 1 : k - 1;
                end
            end
            lws_pkg::FUNC_CLEAR: empty_all();
            default: ;
        endcase
        r.cnt = life_cnt;
        r.tmo = life_tmo;
        r.tim = life_sum;
        r.wcnt = win_fill[5:0];
        r.wtmo = win_tmo;
        r.wsum = win_sum;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s at %0t: expected %0h, got %0h",
                         name, $realtime, want, got);
        end
    endtask

    initial
    begin
        mismatches = 0;
        hole = lws_pkg::HOLE_SIZE_RST;
        min_load = lws_pkg::MIN_SLOT_LOAD_RST;
        empty_all();
    end

    always @(posedge clk)
    begin
        stats_t r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lws_pkg::CFG_HOLE_SIZE)
                    hole = cfg_data[3:0];
                else
                    min_load = cfg_data;
            end
            if (start && !busy)
            begin
                predict_stats(r);
                stats_q.push_back(r);
            end
            if (done)
            begin
                if (stats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result at %0t", $realtime);
                end
                else
                begin
                    r = stats_q.pop_front();
                    check_field("total_count", r.cnt, total_count);
                    check_field("total_timeouts", r.tmo, total_timeouts);
                    check_field("total_time", r.tim, total_time);
                    check_field("window_count", r.wcnt, window_count);
                    check_field("window_timeouts", r.wtmo, window_timeouts);
                    check_field("window_time", r.wsum, window_time);
                    check_field("max_time", r.maxv, max_time);
                    check_field("recent_count", r.rcnt, recent_count);
                    check_field("recent_timeouts", r.rtmo, recent_timeouts);
                    check_field("recent_time", r.rsum, recent_time);
                    check_field("load_start_idx", r.lstart, load_start_idx);
                end
            end
        end
    end

endmodule

/* tb/latency_window_statistics_test.sv */
`timescale 1ns / 1ps
module latency_window_statistics_test;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [31:0] time_idx;
    logic [31:0] since_idx;
    logic [31:0] latency;
    logic        timed_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic [31:0] total_count;
    logic [31:0] total_timeouts;
    logic [63:0] total_time;
    logic [5:0]  window_count;
    logic [5:0]  window_timeouts;
    logic [36:0] window_time;
    logic [31:0] max_time;
    logic [31:0] recent_count;
    logic [31:0] recent_timeouts;
    logic [63:0] recent_time;
    logic [31:0] load_start_idx;
    int          mismatches;
    int          pending;
    int          cycles;
    logic [31:0] now_slot;

    latency_window_statistics dut (.*);

    latency_window_statistics_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(logic [2:0] f, logic [31:0] t, logic [31:0] s,
                             logic [31:0] l, logic to);
        int gap;
        func <= f;
        time_idx <= t;
        since_idx <= s;
        latency <= l;
        timed_out <= to;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = ($urandom_range(0, 9) < 5) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int pick;
        logic [31:0] t;
        logic [31:0] s;
        logic [31:0] l;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            now_slot = now_slot + $urandom_range(4, 20);
        else
            now_slot = now_slot + $urandom_range(0, 3);
        t = now_slot;
        if ($urandom_range(0, 9) == 0)
            t = now_slot - $urandom_range(1, 5);
        s = ($urandom_range(0, 7) == 0) ? $urandom : now_slot - $urandom_range(0, 20);
        l = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
        if (pick < 55)
            send_item(lws_pkg::FUNC_RECORD, t, s, l, $urandom_range(0, 1));
        else if (pick < 65)
            send_item(lws_pkg::FUNC_MAX, t, s, l, $urandom_range(0, 1));
        else if (pick < 77)
            send_item(lws_pkg::FUNC_RECENT, t, s, l, $urandom_range(0, 1));
        else if (pick < 93)
            send_item(lws_pkg::FUNC_LOAD, now_slot + $urandom_range(0, 3), s, l,
                      $urandom_range(0, 1));
        else if (pick < 97)
        begin
            send_item(lws_pkg::FUNC_CLEAR, t, s, l, $urandom_range(0, 1));
            now_slot = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
        end
        else
            send_item(lws_pkg::FUNC_CLEAR + 3'($urandom_range(1, 3)), $urandom, $urandom,
                      $urandom, $urandom_range(0, 1));
    endtask

    initial
    begin
        int ph;
        int k;
        logic [3:0]  holes [5];
        logic [15:0] loads [5];
        rst_n = 1'b0;
        start = 1'b0;
        func = lws_pkg::FUNC_RECORD;
        time_idx = '0;
        since_idx = '0;
        latency = '0;
        timed_out = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lws_pkg::CFG_HOLE_SIZE;
        cfg_data = '0;
        now_slot = 100;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(lws_pkg::FUNC_MAX, 32'd5, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECENT, 32'd5, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_LOAD, 32'd77, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd10, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd10, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_item(lws_pkg::FUNC_RECORD, 32'd3, 32'd0, 32'd9, 1'b1);
        send_item(lws_pkg::FUNC_RECORD, 32'd11, 32'd0, 32'd4, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd11, 32'd0, 32'd4, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd11, 32'd0, 32'd4, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd11, 32'd0, 32'd4, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'd14, 32'd0, 32'd7, 1'b1);
        send_item(lws_pkg::FUNC_MAX, 32'd14, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECENT, 32'd14, 32'd11, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECENT, 32'd14, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECENT, 32'd14, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_LOAD, 32'd15, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_LOAD, 32'd15, 32'd12, 32'd0, 1'b1);
        send_item(lws_pkg::FUNC_CLEAR + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1);
        send_item(lws_pkg::FUNC_CLEAR + 3'd3, 32'd0, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_RECORD, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0);
        send_item(lws_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0);
        send_item(lws_pkg::FUNC_MAX, 32'd0, 32'd0, 32'd0, 1'b0);

        holes[0] = 4'd0;  loads[0] = 16'd0;
        holes[1] = 4'd15; loads[1] = 16'hFFFF;
        holes[2] = 4'd2;  loads[2] = 16'd4;
        holes[3] = 4'($urandom_range(0, 15)); loads[3] = 16'($urandom_range(1, 6));
        holes[4] = 4'd1;  loads[4] = 16'd1;
        for (ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(lws_pkg::CFG_HOLE_SIZE, {12'($urandom), holes[ph]});
            write_reg(lws_pkg::CFG_MIN_SLOT_LOAD, loads[ph]);
            for (k = 0; k < 260; k++)
                random_item();
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
